FILE: rtl/hall_beacon_period_detector_defines.svh
// Assertion macros shared by the beacon period detector RTL.
// No dependencies; included by the files that carry assertions.
`ifndef HALL_BEACON_PERIOD_DETECTOR_DEFINES_SVH
`define HALL_BEACON_PERIOD_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define HBPD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define HBPD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hbpd_pkg.sv
// Types and constants of the beacon period detector.
// No dependencies; imported by hall_beacon_period_detector and hbpd_avg_out.
package hbpd_pkg;

   // ring length and derived widths
   localparam int AVG_LEN = 10;
   localparam int SLOT_W  = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
   localparam int SUM_W   = 32 + $clog2(AVG_LEN);

   // reciprocal used for the divide by AVG_LEN: q ~ (x * RECIP) >> RECIP_SH
   localparam int          RECIP_SH = 31 + $clog2(AVG_LEN);
   localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / AVG_LEN);
   // remainder after the estimate stays below 4*AVG_LEN
   localparam int          REM_W    = $clog2(4 * AVG_LEN);

   // item commands
   localparam logic [1:0] CMD_EDGE    = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MIN_PERIOD    = 2'd0;
   localparam logic [1:0] CSR_MAX_PERIOD    = 2'd1;
   localparam logic [1:0] CSR_IGNORE_EDGES  = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd3;

   // how the reported average is formed for an item
   localparam logic [1:0] AVG_KEEP  = 2'd0;
   localparam logic [1:0] AVG_CLEAR = 2'd1;
   localparam logic [1:0] AVG_NEW   = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] capture_value;
   } hbpd_req_type;

   typedef struct packed {
      logic        station_detected;
      logic [31:0] average_period;
      logic        left_stage;
      logic        edge_ignored;
   } hbpd_rsp_type;

   // status carried alongside the running sum down the averaging pipeline
   typedef struct packed {
      logic       detected;
      logic       ignored;
      logic       left;
      logic [1:0] avg_mode;
   } hbpd_ctl_type;

   typedef struct packed {
      hbpd_ctl_type     ctl;
      logic [SUM_W-1:0] sum;
   } hbpd_stage_type;

endpackage

FILE: rtl/hbpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/hbpd_avg_out.sv
// Averaging back end: divides the ring sum by AVG_LEN over three stages and
// holds the result item for the consumer. Depends on hbpd_pkg.
module hbpd_avg_out import hbpd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  hbpd_stage_type in_stage,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output hbpd_rsp_type   rsp_item
);

   logic ld2, ld3, ldo;
   logic v1_ff, v2_ff, v3_ff, vo_ff;

   hbpd_stage_type         s1_ff;
   hbpd_ctl_type           ctl2_ff, ctl3_ff;
   logic [63:0]            plo_ff;
   logic [31+SUM_W-32:0]   phi_ff;
   logic [REM_W-1:0]       xl2_ff, xl3_ff;
   logic [31:0]            qest_ff;
   logic [31:0]            avg_hold_ff, avg_hold_in;
   hbpd_rsp_type           rsp_ff;

   logic [64+SUM_W-32:0]   prod_full;
   logic [REM_W-1:0]       rem;
   logic [1:0]             corr;
   logic [31:0]            quot;

   // per-stage load enables, back to front
   assign ldo      = !vo_ff || !rsp_stall;
   assign ld3      = !v3_ff || ldo;
   assign ld2      = !v2_ff || ld3;
   assign in_ready = !v1_ff || ld2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (in_ready) v1_ff <= in_valid;
         if (ld2)      v2_ff <= v1_ff;
         if (ld3)      v3_ff <= v2_ff;
         if (ldo)      vo_ff <= v3_ff;
      end
   end

   // stage 1: capture sum and status
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_ff <= in_stage;
      end
   end

   // stage 2: partial products of sum * reciprocal
   always_ff @(posedge clock) begin
      if (ld2 && v1_ff) begin
         ctl2_ff <= s1_ff.ctl;
         plo_ff  <= 64'(s1_ff.sum[31:0]) * 64'(RECIP);
         phi_ff  <= (SUM_W)'(s1_ff.sum[SUM_W-1:32]) * (SUM_W)'(RECIP);
         xl2_ff  <= s1_ff.sum[REM_W-1:0];
      end
   end

   // stage 3: combine partials into the quotient estimate
   assign prod_full = (65+SUM_W-32)'(plo_ff) + ((65+SUM_W-32)'(phi_ff) << 32);

   always_ff @(posedge clock) begin
      if (ld3 && v2_ff) begin
         ctl3_ff <= ctl2_ff;
         qest_ff <= prod_full[RECIP_SH+31:RECIP_SH];
         xl3_ff  <= xl2_ff;
      end
   end

   // correction: estimate is low by at most three
   always_comb begin
      rem = xl3_ff - REM_W'(qest_ff * 32'(AVG_LEN));
      priority if (rem >= REM_W'(3 * AVG_LEN)) begin
         corr = 2'd3;
      end else if (rem >= REM_W'(2 * AVG_LEN)) begin
         corr = 2'd2;
      end else if (rem >= REM_W'(AVG_LEN)) begin
         corr = 2'd1;
      end else begin
         corr = 2'd0;
      end
      quot = qest_ff + 32'(corr);
   end

   // resolve the reported average against the held one
   always_comb begin
      unique case (ctl3_ff.avg_mode)
         AVG_CLEAR: avg_hold_in = '0;
         AVG_NEW:   avg_hold_in = quot;
         default:   avg_hold_in = avg_hold_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_hold_ff <= '0;
      end else if (ldo && v3_ff) begin
         avg_hold_ff <= avg_hold_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (ldo && v3_ff) begin
         rsp_ff.station_detected <= ctl3_ff.detected;
         rsp_ff.average_period   <= avg_hold_in;
         rsp_ff.left_stage       <= ctl3_ff.left;
         rsp_ff.edge_ignored     <= ctl3_ff.ignored;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: rtl/hall_beacon_period_detector.sv
// Beacon period detector top level: edge/tick/restart front end, period ring in RAM.
// Depends on hbpd_pkg, hbpd_ram, hbpd_avg_out and the defines header.
// Each accepted item passes through the divide stages and the output register.
// Throughput: one item per cycle unless stalled; the next ring slot is prefetched.
// Reset: synchronous; resets control state, ring contents read as zero via per-slot
//   valid bits, so there is no clearing pass and items are taken right after reset.
`include "hall_beacon_period_detector_defines.svh"

module hall_beacon_period_detector import hbpd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hbpd_req_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hbpd_rsp_type rsp_item,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   // configuration
   logic [31:0]      min_ff, max_ff, timeout_ff;
   logic [15:0]      ign_edges_ff;
   logic [SUM_W-1:0] min_l_ff, max_l_ff;

   // detector state
   logic [31:0]        last_cap_ff, last_cap_in;
   logic [SUM_W-1:0]   ring_sum_ff, ring_sum_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [AVG_LEN-1:0] ring_vld_ff, ring_vld_in;
   logic [15:0]        ign_cnt_ff, ign_cnt_in;
   logic               left_ff, left_in;
   logic [31:0]        countdown_ff, countdown_in;

   logic               back_ready, accept;
   logic               ram_wr_en;
   logic [31:0]        ram_rd;
   logic [31:0]        period, old_val;
   logic               period_ok, sum_ok;
   logic [SUM_W-1:0]   sum_upd;
   logic [SLOT_W-1:0]  slot_next;
   hbpd_stage_type     stage;

   assign req_stall = !back_ready;
   assign accept    = req_valid && back_ready;

   // configuration writes; scaled window bounds kept for the sum compare
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= '0;
         max_ff       <= '1;
         ign_edges_ff <= 16'd2;
         timeout_ff   <= 32'd1000;
         min_l_ff     <= '0;
         max_l_ff     <= SUM_W'(AVG_LEN) * SUM_W'(32'hFFFF_FFFF) + SUM_W'(AVG_LEN - 1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_PERIOD: begin
               min_ff   <= csr_wdata;
               min_l_ff <= SUM_W'(csr_wdata) * SUM_W'(AVG_LEN);
            end
            CSR_MAX_PERIOD: begin
               max_ff   <= csr_wdata;
               max_l_ff <= SUM_W'(csr_wdata) * SUM_W'(AVG_LEN) + SUM_W'(AVG_LEN - 1);
            end
            CSR_IGNORE_EDGES:  ign_edges_ff <= csr_wdata[15:0];
            CSR_TIMEOUT_TICKS: timeout_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // period, ring update and window checks for a counted edge
   always_comb begin
      period    = req_item.capture_value - last_cap_ff;
      period_ok = (period >= min_ff) && (period <= max_ff);
      old_val   = ring_vld_ff[slot_ff] ? ram_rd : '0;
      sum_upd   = ring_sum_ff - SUM_W'(old_val) + SUM_W'(period);
      sum_ok    = (sum_upd >= min_l_ff) && (sum_upd <= max_l_ff);
      slot_next = (slot_ff == SLOT_W'(AVG_LEN - 1)) ? '0 : slot_ff + 1'b1;
   end

   // per-item next state
   always_comb begin
      last_cap_in  = last_cap_ff;
      ring_sum_in  = ring_sum_ff;
      slot_in      = slot_ff;
      ring_vld_in  = ring_vld_ff;
      ign_cnt_in   = ign_cnt_ff;
      left_in      = left_ff;
      countdown_in = countdown_ff;
      ram_wr_en    = 1'b0;
      stage.ctl.detected = 1'b0;
      stage.ctl.ignored  = 1'b0;
      stage.ctl.avg_mode = AVG_KEEP;
      stage.sum          = sum_upd;

      if (accept) begin
         unique case (req_item.cmd)
            CMD_EDGE: begin
               if (ign_cnt_ff < ign_edges_ff) begin
                  ign_cnt_in        = ign_cnt_ff + 1'b1;
                  stage.ctl.ignored = 1'b1;
               end else begin
                  countdown_in       = timeout_ff;
                  last_cap_in        = req_item.capture_value;
                  stage.ctl.avg_mode = AVG_CLEAR;
                  if (period_ok) begin
                     ram_wr_en              = 1'b1;
                     ring_vld_in[slot_ff]   = 1'b1;
                     ring_sum_in            = sum_upd;
                     slot_in                = slot_next;
                     stage.ctl.avg_mode     = AVG_NEW;
                     if (sum_ok && left_ff) begin
                        stage.ctl.detected = 1'b1;
                        ring_vld_in        = '0;
                        ring_sum_in        = '0;
                        left_in            = 1'b0;
                        ign_cnt_in         = '0;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (countdown_ff != '0) begin
                  if (countdown_ff == 32'd1) begin
                     left_in            = 1'b1;
                     countdown_in       = timeout_ff;
                     stage.ctl.avg_mode = AVG_CLEAR;
                  end else begin
                     countdown_in = countdown_ff - 1'b1;
                  end
               end
            end
            CMD_RESTART: begin
               ring_vld_in = '0;
               ring_sum_in = '0;
               ign_cnt_in  = '0;
            end
            default: ;
         endcase
      end
      stage.ctl.left = left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cap_ff  <= '0;
         ring_sum_ff  <= '0;
         slot_ff      <= '0;
         ring_vld_ff  <= '0;
         ign_cnt_ff   <= '0;
         left_ff      <= 1'b1;
         countdown_ff <= '0;
      end else begin
         last_cap_ff  <= last_cap_in;
         ring_sum_ff  <= ring_sum_in;
         slot_ff      <= slot_in;
         ring_vld_ff  <= ring_vld_in;
         ign_cnt_ff   <= ign_cnt_in;
         left_ff      <= left_in;
         countdown_ff <= countdown_in;
      end
   end

   // period ring; read address runs one slot ahead so the old entry is ready
   hbpd_ram #(
      .WIDTH (32),
      .DEPTH (AVG_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (period),
      .rd_addr (slot_in),
      .rd_data (ram_rd)
   );

   // divide and output register
   hbpd_avg_out u_avg_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (back_ready),
      .in_stage  (stage),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // slot pointer stays inside the ring
   `HBPD_ASSERT_IMP(a_slot_range, clock, reset, 1'b1,
      {1'b0, slot_ff} < (SLOT_W+1)'(AVG_LEN), "ring slot out of range")
   // an empty ring carries a zero sum
   `HBPD_ASSERT_IMP(a_empty_sum, clock, reset, ring_vld_ff == '0,
      ring_sum_ff == '0, "ring sum nonzero with empty ring")
   // a detection empties the ring and drops the flag
   `HBPD_ASSERT_NXT(a_detect_clear, clock, reset, accept && stage.ctl.detected,
      ring_vld_ff == '0 && !left_ff, "detection did not clear ring")
   // countdown expiry raises the left-stage flag
   `HBPD_ASSERT_NXT(a_expiry_left, clock, reset,
      accept && req_item.cmd == CMD_TICK && countdown_ff == 32'd1,
      left_ff, "expiry did not set left flag")

endmodule
